// ===== src/isst_pkg.sv =====
// Shared types, codes and sizes for the indexed sequence store.
package isst_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;
    localparam int QUEUE_DEPTH    = 2;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INS_INDEX = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RM_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RM_BACK   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RM_INDEX  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;
    localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    localparam logic [1:0] OP_INS = 2'd0;
    localparam logic [1:0] OP_RM  = 2'd1;
    localparam logic [1:0] OP_RD  = 2'd2;
    localparam logic [1:0] OP_WR  = 2'd3;

    localparam logic [1:0] SEL_FRONT = 2'd0;
    localparam logic [1:0] SEL_BACK  = 2'd1;
    localparam logic [1:0] SEL_INDEX = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         sel;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
    } t_cmd;

endpackage

// ===== src/isst_front.sv =====
// Request intake: accepts a request and decodes its mode into operation and position select.
module isst_front
    import isst_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value_in,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output t_cmd                o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.pos = i_position;
        n_cmd.val = i_value_in;
        unique case (i_mode)
            MODE_INS_FRONT: begin n_cmd.op = OP_INS; n_cmd.sel = SEL_FRONT; end
            MODE_INS_BACK:  begin n_cmd.op = OP_INS; n_cmd.sel = SEL_BACK;  end
            MODE_INS_INDEX: begin n_cmd.op = OP_INS; n_cmd.sel = SEL_INDEX; end
            MODE_RM_FRONT:  begin n_cmd.op = OP_RM;  n_cmd.sel = SEL_FRONT; end
            MODE_RM_BACK:   begin n_cmd.op = OP_RM;  n_cmd.sel = SEL_BACK;  end
            MODE_RM_INDEX:  begin n_cmd.op = OP_RM;  n_cmd.sel = SEL_INDEX; end
            MODE_READ:      begin n_cmd.op = OP_RD;  n_cmd.sel = SEL_INDEX; end
            default:        begin n_cmd.op = OP_WR;  n_cmd.sel = SEL_INDEX; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/isst_queue.sv =====
// Short request queue between the intake and the execution engine.
module isst_queue
    import isst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd            r_slot [QUEUE_DEPTH];
    logic [QA_W-1:0] r_wp;
    logic [QA_W-1:0] r_rp;
    logic [QC_W-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != QC_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_cmd;
        end
    end

endmodule

// ===== src/isst_back.sv =====
// Execution engine: range checks, element RAM, one-move-per-cycle shifting and result register.
module isst_back
    import isst_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    input  t_cmd                i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STAT_W-1:0]   o_status,
    output logic [VALUE_W-1:0]  o_value_out,
    output logic [COUNT_W-1:0]  o_count_out
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];

    logic [1:0]            r_state,    n_state;
    logic [CW-1:0]         r_occ,      n_occ;
    logic [CW-1:0]         r_new_occ,  n_new_occ;
    logic [AW-1:0]         r_src,      n_src;
    logic [AW-1:0]         r_wdst,     n_wdst;
    logic [CW-1:0]         r_left,     n_left;
    logic                  r_pend,     n_pend;
    logic                  r_up,       n_up;
    logic                  r_fin_we,   n_fin_we;
    logic [AW-1:0]         r_fin_addr, n_fin_addr;
    logic [DATA_WIDTH-1:0] r_val,      n_val;
    logic [STAT_W-1:0]     r_stat,     n_stat;
    logic                  r_is_rd,    n_is_rd;
    logic [DATA_WIDTH-1:0] r_rdata;
    logic                  r_out_valid, n_out_valid;
    logic [STAT_W-1:0]     r_out_stat;
    logic [VALUE_W-1:0]    r_out_val;
    logic [COUNT_W-1:0]    r_out_cnt;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  load_out;
    logic [PW-1:0]         ext_pos;
    logic [PW-1:0]         ext_occ;
    logic [PW-1:0]         at;
    logic [DATA_WIDTH+VALUE_W-1:0] wide_in;
    logic [DATA_WIDTH+VALUE_W-1:0] wide_rd;
    logic [PW+COUNT_W-1:0]         wide_cnt;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_stat;
    assign o_value_out = r_out_val;
    assign o_count_out = r_out_cnt;

    assign ext_pos  = PW'(i_cmd.pos);
    assign ext_occ  = PW'(r_occ);
    assign wide_in  = {{DATA_WIDTH{1'b0}}, i_cmd.val};
    assign wide_rd  = {{VALUE_W{1'b0}}, r_rdata};
    assign wide_cnt = {{COUNT_W{1'b0}}, PW'(r_new_occ)};

    always_comb begin
        unique case (i_cmd.sel)
            SEL_FRONT: at = '0;
            SEL_BACK:  at = (i_cmd.op == OP_INS) ? ext_occ : ext_occ - 1'b1;
            default:   at = ext_pos;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_new_occ   = r_new_occ;
        n_src       = r_src;
        n_wdst      = r_wdst;
        n_left      = r_left;
        n_pend      = r_pend;
        n_up        = r_up;
        n_fin_we    = r_fin_we;
        n_fin_addr  = r_fin_addr;
        n_val       = r_val;
        n_stat      = r_stat;
        n_is_rd     = r_is_rd;
        n_out_valid = r_out_valid && !i_out_ready;
        rd_en       = 1'b0;
        rd_addr     = r_src;
        wr_en       = 1'b0;
        wr_addr     = r_wdst;
        wr_data     = r_rdata;
        load_out    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_val      = wide_in[DATA_WIDTH-1:0];
                    n_stat     = STAT_OK;
                    n_new_occ  = r_occ;
                    n_fin_we   = 1'b0;
                    n_fin_addr = AW'(at);
                    n_is_rd    = 1'b0;
                    n_left     = '0;
                    n_pend     = 1'b0;
                    n_state    = S_FIN;
                    unique case (i_cmd.op)
                        OP_INS: begin
                            if (at > ext_occ) begin
                                n_stat = STAT_RANGE;
                            end else if (ext_occ >= PW'(CAPACITY)) begin
                                n_stat = STAT_FULL;
                            end else begin
                                n_new_occ = r_occ + 1'b1;
                                n_fin_we  = 1'b1;
                                n_left    = CW'(ext_occ - at);
                                n_src     = AW'(ext_occ - 1'b1);
                                n_wdst    = AW'(ext_occ);
                                n_up      = 1'b0;
                                if (ext_occ != at) begin
                                    n_state = S_SHIFT;
                                end
                            end
                        end
                        OP_RM: begin
                            if (i_cmd.sel != SEL_INDEX && r_occ == '0) begin
                                n_stat = STAT_EMPTY;
                            end else if (at >= ext_occ) begin
                                n_stat = STAT_RANGE;
                            end else begin
                                n_new_occ = r_occ - 1'b1;
                                n_left    = CW'(ext_occ - at - 1'b1);
                                n_src     = AW'(at + 1'b1);
                                n_wdst    = AW'(at);
                                n_up      = 1'b1;
                                if (ext_occ - at != PW'(1)) begin
                                    n_state = S_SHIFT;
                                end
                            end
                        end
                        OP_RD: begin
                            if (at >= ext_occ) begin
                                n_stat = STAT_RANGE;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(at);
                                n_is_rd = 1'b1;
                            end
                        end
                        default: begin
                            if (at >= ext_occ) begin
                                n_stat = STAT_RANGE;
                            end else begin
                                n_fin_we = 1'b1;
                            end
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_left != '0) begin
                    rd_en  = 1'b1;
                    n_src  = r_up ? r_src + 1'b1 : r_src - 1'b1;
                    n_left = r_left - 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    wr_en  = 1'b1;
                    n_wdst = r_up ? r_wdst + 1'b1 : r_wdst - 1'b1;
                end
                if (r_left == '0 && !r_pend) begin
                    n_state = S_FIN;
                end
            end
            default: begin
                if (!r_out_valid || i_out_ready) begin
                    wr_en       = r_fin_we;
                    wr_addr     = r_fin_addr;
                    wr_data     = r_val;
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_occ       = r_new_occ;
                    n_state     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_pend      <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_pend      <= n_pend;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_occ  <= n_new_occ;
        r_src      <= n_src;
        r_wdst     <= n_wdst;
        r_up       <= n_up;
        r_fin_we   <= n_fin_we;
        r_fin_addr <= n_fin_addr;
        r_val      <= n_val;
        r_stat     <= n_stat;
        r_is_rd    <= n_is_rd;
        if (load_out) begin
            r_out_stat <= r_stat;
            r_out_val  <= (r_is_rd && r_stat == STAT_OK) ? wide_rd[VALUE_W-1:0] : '0;
            r_out_cnt  <= wide_cnt[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

endmodule

// ===== src/indexed_sequence_store_top.sv =====
// Top level of the indexed sequence store: intake, request queue and execution engine.
//
// An ordered store of up to CAPACITY elements of DATA_WIDTH bits. Each request
// (mode, position, value_in) returns one result: status, value_out and the
// count after the request. Requests are carried out one at a time by an engine
// behind a two-entry queue, so new requests are taken while an earlier one
// runs and while a finished result waits. A read, an overwrite, a request that
// fails and an insert or remove that moves no element go from the idle state
// straight to the finish state. An insert at index k with n elements stored
// moves n-k elements and a remove moves n-k-1, one per cycle through the
// element RAM with its one read and one write port, in a shift state between
// idle and finish. The finish state loads the result register once it is
// free, and the engine then returns to idle. The element RAM needs no
// clearing after reset.
module indexed_sequence_store_top
    import isst_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [POS_W-1:0]    i_position,
    input  logic [VALUE_W-1:0]  i_value_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STAT_W-1:0]   o_status,
    output logic [VALUE_W-1:0]  o_value_out,
    output logic [COUNT_W-1:0]  o_count_out
);

    logic f_valid;
    logic f_ready;
    t_cmd f_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    isst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_position  (i_position),
        .i_value_in  (i_value_in),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    isst_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_cmd   (f_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    isst_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count_out (o_count_out)
    );

endmodule
